FILE: hdl/pepm_pkg.sv
package pepm_pkg;

   // register indexes on the csr port
   localparam logic [1:0] REG_RESOLUTION_WATT = 2'd0;
   localparam logic [1:0] REG_MAX_AGGREGATION = 2'd1;
   localparam logic [1:0] REG_DEBOUNCE_MS     = 2'd2;

   // item kinds on req_tuser
   localparam logic MODE_PULSE = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int NOW_BITS      = 32;
   localparam int POWER_BITS    = 36;
   localparam int ENERGY_BITS   = 32;
   localparam int AGG_BITS      = 16;
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 88;
   localparam int RSP_USER_BITS = 2;

   localparam logic [POWER_BITS-1:0]    POWER_MAX      = {POWER_BITS{1'b1}};
   localparam logic [CSR_DATA_BITS-1:0] DEBOUNCE_RESET = 16'd500;

   // status of the serial multiply/divide unit
   typedef struct packed {
      logic busy;
      logic done;
   } md_status_type;

endpackage

FILE: hdl/pepm_muldiv.sv
// serial power unit: quotient = (mcand * mplier * 16) / divisor
// one multiplier bit per cycle, then one quotient bit per cycle (restoring)
module pepm_muldiv #(
   parameter int WIN_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [15:0]                mcand,
   input  logic [WIN_BITS-1:0]        mplier,
   input  logic [15:0]                divisor,
   output pepm_pkg::md_status_type    status,
   output logic [WIN_BITS+19:0]       quotient
);

   localparam int NUM_BITS = WIN_BITS + 20;
   localparam int ACC_BITS = WIN_BITS + 16;
   localparam int CNT_BITS = $clog2(NUM_BITS);

   typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} phase_type;

   phase_type             phase_ff, phase_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [15:0]           mcand_ff, mcand_in;
   logic [WIN_BITS-1:0]   mplier_ff, mplier_in;
   logic [15:0]           den_ff, den_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [NUM_BITS-1:0]   num_ff, num_in;
   logic [15:0]           rem_ff, rem_in;
   logic                  done_ff, done_in;

   logic [16:0]           trial;
   logic [16:0]           diff;
   logic                  ge;
   logic [ACC_BITS-1:0]   addend;

   assign trial  = {rem_ff, num_ff[NUM_BITS-1]};
   assign diff   = trial - {1'b0, den_ff};
   assign ge     = trial >= {1'b0, den_ff};
   assign addend = mcand_ff[15] ? ACC_BITS'(mplier_ff) : '0;

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      den_in    = den_ff;
      acc_in    = acc_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      done_in   = 1'b0;
      unique case (phase_ff)
         MD_IDLE: begin
            if (start) begin
               mcand_in  = mcand;
               mplier_in = mplier;
               den_in    = divisor;
               acc_in    = '0;
               cnt_in    = CNT_BITS'(15);
               phase_in  = MD_MUL;
            end
         end
         MD_MUL: begin
            // msb first shift-add
            acc_in   = {acc_ff[ACC_BITS-2:0], 1'b0} + addend;
            mcand_in = {mcand_ff[14:0], 1'b0};
            if (cnt_ff == '0) begin
               num_in   = {acc_in, 4'b0000};
               rem_in   = '0;
               cnt_in   = CNT_BITS'(NUM_BITS - 1);
               phase_in = MD_DIV;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         MD_DIV: begin
            // numerator shifts out at the top, quotient bits shift in below
            num_in = {num_ff[NUM_BITS-2:0], ge};
            rem_in = ge ? diff[15:0] : trial[15:0];
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               phase_in = MD_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            phase_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      den_ff    <= den_in;
      acc_ff    <= acc_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
   end

   assign status.busy = phase_ff != MD_IDLE;
   assign status.done = done_ff;
   assign quotient    = num_ff;

endmodule

FILE: hdl/pulse_energy_power_meter_core.sv
// S0 pulse energy meter with power calculation. Each req beat is a pulse falling
// edge (req_tuser = 0, millisecond timestamp in req_tdata) or a measure-interval
// tick (req_tuser = 1). An edge counts when at least debounce_ms ms (mod 2^32)
// have passed since the previous edge; it then bumps the saturating window count
// and the wrapping energy count. A tick either merges one more empty interval
// (clearing power above one resolution step) or recomputes power as
// floor(resolution_watt * window * 16 / merged intervals), saturated to 36 bits,
// in sixteenths of a watt. Every item yields exactly one rsp beat carrying the
// current power, energy, merge count and two event flags. A pulse or a merging
// tick updates the meter state, and ST_OUT copies it into the rsp register when
// that register is free; a recomputing tick first waits in ST_BUSY for the
// bit-serial multiply and the one-bit-per-cycle restoring divide. One item is in
// work at a time; a finished beat may wait in the rsp register while the next
// item is taken. Configuration is written through csr_we/csr_addr/csr_wdata;
// the user must write it only while idle; the block does not enforce that.
module pulse_energy_power_meter_core #(
   parameter int WINDOW_COUNT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request side
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pepm_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // now_ms[31:0]
   input  logic                                 req_tuser,  // mode
   // response side
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // power_q4[35:0], energy_pulses[67:36], merged_intervals[83:68], zero pad
   output logic [pepm_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // pulse_accepted[0], power_updated[1]
   output logic [pepm_pkg::RSP_USER_BITS-1:0]   rsp_tuser,
   // register writes
   input  logic                                 csr_we,
   input  logic [pepm_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [pepm_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int NUM_BITS = WINDOW_COUNT_BITS + 20;
   localparam int PW = (NUM_BITS > pepm_pkg::POWER_BITS) ? NUM_BITS : pepm_pkg::POWER_BITS;

   typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_OUT} state_type;

   // control
   state_type                              state_ff, state_in;
   logic                                   rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [15:0]                            res_ff, res_in;
   logic [15:0]                            maxagg_ff, maxagg_in;
   logic [15:0]                            deb_ff, deb_in;

   // meter state
   logic [pepm_pkg::NOW_BITS-1:0]          last_ff, last_in;
   logic [WINDOW_COUNT_BITS-1:0]           win_ff, win_in;
   logic [pepm_pkg::ENERGY_BITS-1:0]       energy_ff, energy_in;
   logic [pepm_pkg::AGG_BITS-1:0]          agg_ff, agg_in;
   logic [pepm_pkg::POWER_BITS-1:0]        power_ff, power_in;
   logic                                   acc_flag_ff, acc_flag_in;
   logic                                   upd_flag_ff, upd_flag_in;

   // rsp register
   logic [pepm_pkg::POWER_BITS-1:0]        rsp_power_ff, rsp_power_in;
   logic [pepm_pkg::ENERGY_BITS-1:0]       rsp_energy_ff, rsp_energy_in;
   logic [pepm_pkg::AGG_BITS-1:0]          rsp_agg_ff, rsp_agg_in;
   logic                                   rsp_acc_ff, rsp_acc_in;
   logic                                   rsp_upd_ff, rsp_upd_in;

   logic                                   accept;
   logic [pepm_pkg::NOW_BITS-1:0]          gap;
   logic                                   pass;
   logic                                   merge;
   logic                                   md_start;
   pepm_pkg::md_status_type                md_status;
   logic [NUM_BITS-1:0]                    md_quot;
   logic [PW-1:0]                          quot_ext;
   logic                                   quot_sat;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;

   // debounce: wrap-around gap since the previous edge
   assign gap  = req_tdata[pepm_pkg::NOW_BITS-1:0] - last_ff;
   assign pass = gap >= {16'd0, deb_ff};

   // empty window and room left to merge another interval
   assign merge    = (win_ff == '0) && (agg_ff < maxagg_ff);
   assign md_start = accept && (req_tuser == pepm_pkg::MODE_TICK) && !merge;

   assign quot_ext = PW'(md_quot);
   assign quot_sat = quot_ext > PW'(pepm_pkg::POWER_MAX);

   pepm_muldiv #(
      .WIN_BITS (WINDOW_COUNT_BITS)
   ) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (md_start),
      .mcand    (res_ff),
      .mplier   (win_ff),
      .divisor  (agg_ff),
      .status   (md_status),
      .quotient (md_quot)
   );

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      res_in        = res_ff;
      maxagg_in     = maxagg_ff;
      deb_in        = deb_ff;
      last_in       = last_ff;
      win_in        = win_ff;
      energy_in     = energy_ff;
      agg_in        = agg_ff;
      power_in      = power_ff;
      acc_flag_in   = acc_flag_ff;
      upd_flag_in   = upd_flag_ff;
      rsp_power_in  = rsp_power_ff;
      rsp_energy_in = rsp_energy_ff;
      rsp_agg_in    = rsp_agg_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_upd_in    = rsp_upd_ff;

      // register writes; the user keeps them to idle, the block does not enforce it
      if (csr_we) begin
         unique case (csr_addr)
            pepm_pkg::REG_RESOLUTION_WATT: res_in    = csr_wdata;
            pepm_pkg::REG_MAX_AGGREGATION: maxagg_in = csr_wdata;
            pepm_pkg::REG_DEBOUNCE_MS:     deb_in    = csr_wdata;
            default: ;
         endcase
      end

      // a waiting beat leaves when taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               acc_flag_in = 1'b0;
               upd_flag_in = 1'b0;
               if (req_tuser == pepm_pkg::MODE_PULSE) begin
                  if (pass) begin
                     if (win_ff != '1) begin
                        win_in = win_ff + 1'b1;
                     end
                     energy_in   = energy_ff + 1'b1;
                     acc_flag_in = 1'b1;
                  end
                  last_in  = req_tdata[pepm_pkg::NOW_BITS-1:0];
                  state_in = ST_OUT;
               end else begin
                  win_in = '0;
                  if (merge) begin
                     agg_in = agg_ff + 1'b1;
                     // drop power above one resolution step
                     if (power_ff > {16'd0, res_ff, 4'b0000}) begin
                        power_in = '0;
                     end
                     state_in = ST_OUT;
                  end else begin
                     state_in = ST_BUSY;
                  end
               end
            end
         end
         ST_BUSY: begin
            if (md_status.done) begin
               power_in    = quot_sat ? pepm_pkg::POWER_MAX
                                      : quot_ext[pepm_pkg::POWER_BITS-1:0];
               agg_in      = 16'd1;
               upd_flag_in = 1'b1;
               state_in    = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_power_in  = power_ff;
               rsp_energy_in = energy_ff;
               rsp_agg_in    = agg_ff;
               rsp_acc_in    = acc_flag_ff;
               rsp_upd_in    = upd_flag_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         res_ff       <= 16'd1;
         maxagg_ff    <= 16'd1;
         deb_ff       <= pepm_pkg::DEBOUNCE_RESET;
         last_ff      <= '0;
         win_ff       <= '0;
         energy_ff    <= '0;
         agg_ff       <= 16'd1;
         power_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         res_ff       <= res_in;
         maxagg_ff    <= maxagg_in;
         deb_ff       <= deb_in;
         last_ff      <= last_in;
         win_ff       <= win_in;
         energy_ff    <= energy_in;
         agg_ff       <= agg_in;
         power_ff     <= power_in;
      end
      acc_flag_ff   <= acc_flag_in;
      upd_flag_ff   <= upd_flag_in;
      rsp_power_ff  <= rsp_power_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_agg_ff    <= rsp_agg_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_upd_ff    <= rsp_upd_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_agg_ff, rsp_energy_ff, rsp_power_ff};
   assign rsp_tuser  = {rsp_upd_ff, rsp_acc_ff};

   // merge count never drops to zero
   a_agg_nonzero: assert property (@(posedge clock) disable iff (reset)
      agg_ff != 16'd0)
      else $error("aggregation count is zero");

   // a recomputed power always restarts aggregation at one
   a_upd_agg_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_upd_ff |-> rsp_agg_ff == 16'd1)
      else $error("power update without aggregation reset");

   // one beat never carries both event flags
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_acc_ff && rsp_upd_ff))
      else $error("pulse and power flags both set");

   // every tick empties the window
   a_tick_clears: assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser == pepm_pkg::MODE_TICK) |=> win_ff == '0)
      else $error("window not cleared by tick");

   // the divider only finishes while a tick waits for it
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      md_status.done |-> state_ff == ST_BUSY)
      else $error("divider done outside busy state");

   // divider is free whenever new items are taken
   a_idle_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !md_status.busy)
      else $error("divider busy while idle");

endmodule

FILE: tb/sv/tb_pulse_energy_power_meter_core.sv
`timescale 1ns / 1ps

module tb_pulse_energy_power_meter_core;
   import pepm_pkg::*;

   localparam int WIN_BITS    = 16;
   localparam int IDLE_PCT    = 36;
   localparam int STUCK_LIMIT = 2000;
   localparam int PAD_LSB     = POWER_BITS + ENERGY_BITS + AGG_BITS;

   typedef struct packed {
      logic                mode;
      logic [NOW_BITS-1:0] now_ms;
   } meter_event_type;

   typedef struct packed {
      logic [POWER_BITS-1:0]  power_q4;
      logic [ENERGY_BITS-1:0] energy;
      logic [AGG_BITS-1:0]    merged;
      logic                   accepted;
      logic                   updated;
   } meter_reading_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;   // now_ms[31:0]
   logic                     req_tuser = 1'b0; // mode
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // power_q4[35:0], energy_pulses[67:36], merged_intervals[83:68], zero pad
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   // pulse_accepted[0], power_updated[1]
   logic [RSP_USER_BITS-1:0] rsp_tuser;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   meter_event_type   pending_events[$];
   meter_reading_type expected_readings[$];

   int  queued_total   = 0;
   int  accepted_total = 0;
   int  reading_count  = 0;
   int  mismatches     = 0;
   int  stuck_cycles   = 0;
   bit  req_fired      = 1'b0;
   bit  no_stall       = 1'b0;

   // predictor copy of the configuration
   logic [CSR_DATA_BITS-1:0] cfg_resolution;
   logic [CSR_DATA_BITS-1:0] cfg_max_merge;
   logic [CSR_DATA_BITS-1:0] cfg_debounce;

   // predictor copy of the meter state
   logic [NOW_BITS-1:0]    m_last_edge;
   logic [WIN_BITS-1:0]    m_window;
   logic [ENERGY_BITS-1:0] m_energy;
   logic [AGG_BITS-1:0]    m_merged;
   logic [POWER_BITS-1:0]  m_power;

   pulse_energy_power_meter_core #(
      .WINDOW_COUNT_BITS(WIN_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // advances the meter by one edge or tick and returns the reading it reports
   function automatic meter_reading_type meter_step(input logic mode,
                                                    input logic [NOW_BITS-1:0] now);
      meter_reading_type   reading;
      logic [NOW_BITS-1:0] gap;
      logic [63:0]      res_w;
      logic [63:0]      win_w;
      logic [63:0]      den_w;
      logic [63:0]      quot;
      reading = '0;
      if (mode == MODE_PULSE) begin
         // timestamp is kept on every edge, counted or bounced
         gap = now - m_last_edge;
         if (gap >= NOW_BITS'(cfg_debounce)) begin
            if (m_window != {WIN_BITS{1'b1}}) begin
               m_window = m_window + 1'b1;
            end
            m_energy = m_energy + 1'b1;
            reading.accepted = 1'b1;
         end
         m_last_edge = now;
      end else begin
         if (m_window == '0 && m_merged < cfg_max_merge) begin
            // empty window: merge one more interval, drop power above one step
            m_merged = m_merged + 1'b1;
            if (m_power > {cfg_resolution, 4'b0000}) begin
               m_power = '0;
            end
         end else begin
            res_w = '0;
            win_w = '0;
            den_w = '0;
            res_w[CSR_DATA_BITS-1:0] = cfg_resolution;
            win_w[WIN_BITS-1:0]      = m_window;
            den_w[AGG_BITS-1:0]      = m_merged;
            if (den_w == 64'd0) begin
               den_w = 64'd1;
            end
            quot = (res_w * win_w * 64'd16) / den_w;
            m_power = (quot > 64'(POWER_MAX)) ? POWER_MAX : quot[POWER_BITS-1:0];
            m_merged = 16'd1;
            reading.updated = 1'b1;
         end
         m_window = '0;
      end
      reading.power_q4 = m_power;
      reading.energy   = m_energy;
      reading.merged   = m_merged;
      return reading;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("%0t: reading %0d %s: got %0h, expected %0h",
               $realtime, reading_count, field, got, want);
   endtask

   task automatic push_event(input logic mode, input logic [NOW_BITS-1:0] now);
      meter_event_type ev;
      ev.mode   = mode;
      ev.now_ms = now;
      pending_events.push_back(ev);
      queued_total++;
   endtask

   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic write_all(input logic [CSR_DATA_BITS-1:0] res_v,
                            input logic [CSR_DATA_BITS-1:0] merge_v,
                            input logic [CSR_DATA_BITS-1:0] deb_v);
      write_reg(REG_RESOLUTION_WATT, res_v);
      write_reg(REG_MAX_AGGREGATION, merge_v);
      write_reg(REG_DEBOUNCE_MS, deb_v);
   endtask

   // block until every queued beat went in and every reading came back
   task automatic wait_idle(input int settle);
      while (accepted_total != queued_total || expected_readings.size() != 0) begin
         @(posedge clock);
      end
      repeat (settle) @(posedge clock);
   endtask

   // drives req and rsp_tready: a beat stays up until taken, then the next may follow
   always @(negedge clock) begin
      meter_event_type ev;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
         if (!req_tvalid || req_fired) begin
            if (pending_events.size() != 0 && (no_stall || $urandom_range(99) >= IDLE_PCT)) begin
               ev = pending_events.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= ev.now_ms;
               req_tuser  <= ev.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: predict on every accepted request, check every accepted response
   always @(posedge clock) begin
      meter_reading_type want;
      if (reset) begin
         req_fired      <= 1'b0;
         cfg_resolution = 16'd1;
         cfg_max_merge  = 16'd1;
         cfg_debounce   = DEBOUNCE_RESET;
         m_last_edge    = '0;
         m_window       = '0;
         m_energy       = '0;
         m_merged       = 16'd1;
         m_power        = '0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         if (csr_we) begin
            case (csr_addr)
               REG_RESOLUTION_WATT: cfg_resolution = csr_wdata;
               REG_MAX_AGGREGATION: cfg_max_merge  = csr_wdata;
               REG_DEBOUNCE_MS:     cfg_debounce   = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(meter_step(req_tuser, req_tdata));
            accepted_total++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               report_mismatch("beat with nothing expected", rsp_tdata[63:0], '0);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_tdata[POWER_BITS-1:0] != want.power_q4)
                  report_mismatch("power_q4", 64'(rsp_tdata[POWER_BITS-1:0]),
                                  64'(want.power_q4));
               if (rsp_tdata[POWER_BITS +: ENERGY_BITS] != want.energy)
                  report_mismatch("energy_pulses", 64'(rsp_tdata[POWER_BITS +: ENERGY_BITS]),
                                  64'(want.energy));
               if (rsp_tdata[POWER_BITS+ENERGY_BITS +: AGG_BITS] != want.merged)
                  report_mismatch("merged_intervals",
                                  64'(rsp_tdata[POWER_BITS+ENERGY_BITS +: AGG_BITS]),
                                  64'(want.merged));
               if (rsp_tdata[RSP_DATA_BITS-1:PAD_LSB] != '0)
                  report_mismatch("pad bits", 64'(rsp_tdata[RSP_DATA_BITS-1:PAD_LSB]), '0);
               if (rsp_tuser[0] != want.accepted)
                  report_mismatch("pulse_accepted", 64'(rsp_tuser[0]), 64'(want.accepted));
               if (rsp_tuser[1] != want.updated)
                  report_mismatch("power_updated", 64'(rsp_tuser[1]), 64'(want.updated));
            end
            reading_count++;
         end
      end
   end

   // watchdog: too long without any beat on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("pulse_energy_power_meter_core test failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int                       phase;
      int                       made;
      int                       burst;
      int                       pick;
      logic [NOW_BITS-1:0]      stamp;
      logic [CSR_DATA_BITS-1:0] res_v;
      logic [CSR_DATA_BITS-1:0] merge_v;
      logic [CSR_DATA_BITS-1:0] deb_v;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: debounce 500, no merging
      push_event(MODE_PULSE, 32'd0);          // gap 0 from reset timestamp, bounced
      push_event(MODE_PULSE, 32'd500);        // exactly the debounce time
      push_event(MODE_PULSE, 32'd999);        // bounce, but its timestamp is kept
      push_event(MODE_PULSE, 32'd1499);       // 500 after the bounced edge
      push_event(MODE_PULSE, 32'hFFFF_FFFF);  // top of the timestamp range
      push_event(MODE_PULSE, 32'd499);        // gap wraps through zero to 500
      push_event(MODE_TICK, 32'hFFFF_FFFF);   // recompute from four pulses
      push_event(MODE_TICK, 32'd0);           // empty window, limit 1: recompute to 0
      wait_idle(4);

      // merging: power above one step is cleared, floor division by merged count
      write_all(16'd2, 16'd3, 16'd0);
      push_event(MODE_PULSE, 32'd5);
      push_event(MODE_PULSE, 32'd5);          // same timestamp still passes debounce 0
      push_event(MODE_TICK, 32'd0);           // 2 * 2 * 16 = 64
      push_event(MODE_TICK, 32'd0);           // merge, 64 > 32 cleared
      push_event(MODE_TICK, 32'd0);           // merge up to the limit
      push_event(MODE_TICK, 32'd0);           // at limit with empty window: recompute
      push_event(MODE_TICK, 32'd0);           // merge
      push_event(MODE_TICK, 32'd0);           // merge
      push_event(MODE_PULSE, 32'd77);
      push_event(MODE_TICK, 32'd0);           // 2 * 1 * 16 / 3 rounded down
      push_event(MODE_PULSE, 32'd78);
      push_event(MODE_TICK, 32'd0);           // power equal to one step
      push_event(MODE_TICK, 32'd0);           // merge keeps a power of exactly one step
      wait_idle(4);

      // long run without stalls at full resolution
      write_all(16'hFFFF, 16'd1, 16'd0);
      no_stall = 1'b1;
      for (made = 0; made < 60; made++) begin
         push_event(MODE_PULSE, $urandom);
      end
      push_event(MODE_TICK, $urandom);
      push_event(MODE_TICK, $urandom);
      wait_idle(4);
      no_stall = 1'b0;

      // random phases, each with its own settings
      stamp = $urandom;
      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin res_v = 16'd1;      merge_v = 16'd0;      deb_v = 16'd0;      end
            1: begin res_v = 16'hFFFF;   merge_v = 16'hFFFF;   deb_v = 16'hFFFF;   end
            2: begin
               res_v   = 16'd0;
               merge_v = 16'd2;
               deb_v   = 16'($urandom_range(1000, 1));
            end
            3: begin
               res_v   = 16'($urandom_range(65535, 1));
               merge_v = 16'($urandom_range(4, 1));
               deb_v   = 16'($urandom_range(2000));
            end
            default: begin
               res_v   = $urandom_range(1) ? 16'($urandom_range(300, 1))
                                           : 16'($urandom_range(65535, 1));
               merge_v = 16'($urandom_range(16));
               deb_v   = $urandom_range(1) ? 16'($urandom_range(1000))
                                           : 16'($urandom_range(65535));
            end
         endcase
         write_all(res_v, merge_v, deb_v);
         made = 0;
         while (made < 85) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
               // run of ticks so empty windows get merged
               burst = $urandom_range(4, 1);
               repeat (burst) push_event(MODE_TICK, $urandom);
               made += burst;
            end else begin
               if (pick < 85) begin
                  stamp = stamp + deb_v + $urandom_range(300);   // clean pulse
               end else if (pick < 95) begin
                  stamp = stamp + $urandom_range(deb_v);         // contact bounce
               end else begin
                  stamp = $urandom;                              // arbitrary timestamp
               end
               push_event(MODE_PULSE, stamp);
               made++;
            end
         end
         wait_idle(4);
      end

      wait_idle(60);
      if (mismatches == 0) begin
         $display("pulse_energy_power_meter_core test passed");
      end else begin
         $display("pulse_energy_power_meter_core test failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/pepm_pkg.sv
hdl/pepm_muldiv.sv
hdl/pulse_energy_power_meter_core.sv
tb/sv/tb_pulse_energy_power_meter_core.sv
